// ===== design/ilha_pkg.sv =====
// Shared types, constants and helpers of the heap allocator.
package ilha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam logic [31:0] CHUNK_BYTES    = 32'd4096;
  localparam logic [31:0] MIN_BLOCK      = 32'd16;
  localparam logic [31:0] LIST_START     = 32'd8;
  localparam logic [31:0] DSIZE          = 32'd8;
  localparam logic [31:0] WSIZE          = 32'd4;
  localparam logic [31:0] TAG_ALLOC      = 32'd1;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_REALLOC = 2'd3
  } cmd_e;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [31:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic logic [31:0] tag_size(input logic [31:0] tag);
    tag_size = {tag[31:3], 3'b000};
  endfunction

endpackage

// ===== design/ilha_mem.sv =====
// Heap word memory: one port, synchronous read, out-of-range reads give zero.
module ilha_mem #(
  parameter int unsigned HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
  input  logic               clk_i,
  input  ilha_pkg::mem_req_t mem_req_i,
  output logic [31:0]        mem_rdata_o
);

  localparam int unsigned WORDS = HEAP_BYTES / 4;
  localparam int unsigned IW    = $clog2(WORDS);

  logic [31:0]   mem_q [WORDS];
  logic [31:0]   rdata_q;
  logic          rng_q;
  logic          in_range;
  logic [IW-1:0] idx;

  assign in_range = mem_req_i.addr[31:2] < 30'(WORDS);
  assign idx      = mem_req_i.addr[IW+1:2];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we && in_range) begin
      mem_q[idx] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[idx];
      rng_q   <= in_range;
    end
  end

  assign mem_rdata_o = rng_q ? rdata_q : 32'd0;

endmodule

// ===== design/ilha_ctrl.sv =====
// Command sequencer: tag walk, split, extend and coalesce over the heap memory.
module ilha_ctrl #(
  parameter int unsigned HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        block_addr_i,
  input  logic [15:0]        request_bytes_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        result_addr_o,
  output logic               status_o,
  output ilha_pkg::mem_req_t mem_req_o,
  input  logic [31:0]        mem_rdata_i
);

  localparam int unsigned BW     = $clog2(HEAP_BYTES + 1);
  localparam logic [31:0] HEAP32 = 32'(HEAP_BYTES);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_INIT0 = 6'd1;
  localparam logic [5:0] S_INIT1 = 6'd2;
  localparam logic [5:0] S_INIT2 = 6'd3;
  localparam logic [5:0] S_INIT3 = 6'd4;
  localparam logic [5:0] S_EXT   = 6'd5;
  localparam logic [5:0] S_EXTW2 = 6'd6;
  localparam logic [5:0] S_FFR   = 6'd7;
  localparam logic [5:0] S_FFD   = 6'd8;
  localparam logic [5:0] S_PUT   = 6'd9;
  localparam logic [5:0] S_PUT1  = 6'd10;
  localparam logic [5:0] S_PSR2  = 6'd11;
  localparam logic [5:0] S_PSN   = 6'd12;
  localparam logic [5:0] S_ADONE = 6'd13;
  localparam logic [5:0] S_FREE  = 6'd14;
  localparam logic [5:0] S_FR1   = 6'd15;
  localparam logic [5:0] S_HFW   = 6'd16;
  localparam logic [5:0] S_HFR   = 6'd17;
  localparam logic [5:0] S_HFF   = 6'd18;
  localparam logic [5:0] S_MG0   = 6'd19;
  localparam logic [5:0] S_MG1   = 6'd20;
  localparam logic [5:0] S_MG2   = 6'd21;
  localparam logic [5:0] S_MG3   = 6'd22;
  localparam logic [5:0] S_MG4   = 6'd23;
  localparam logic [5:0] S_MG5   = 6'd24;
  localparam logic [5:0] S_MBW0  = 6'd25;
  localparam logic [5:0] S_MBR0  = 6'd26;
  localparam logic [5:0] S_MBR1  = 6'd27;
  localparam logic [5:0] S_MC0   = 6'd28;
  localparam logic [5:0] S_MCW0  = 6'd29;
  localparam logic [5:0] S_MCR1  = 6'd30;
  localparam logic [5:0] S_MCR2  = 6'd31;
  localparam logic [5:0] S_MCW1  = 6'd32;
  localparam logic [5:0] S_MCR3  = 6'd33;
  localparam logic [5:0] S_MCF   = 6'd34;
  localparam logic [5:0] S_MRET  = 6'd35;
  localparam logic [5:0] S_DONE  = 6'd36;

  localparam logic [1:0] C_INIT  = 2'd0;
  localparam logic [1:0] C_ALLOC = 2'd1;
  localparam logic [1:0] C_FREE  = 2'd2;

  logic [5:0]    state_q, state_d, hret_q, hret_d;
  logic [1:0]    caller_q, caller_d;
  logic [BW-1:0] brk_q, brk_d;
  logic          ok_q, ok_d, pa_q, pa_d;
  logic          out_valid_q, out_valid_d;

  ilha_pkg::cmd_e cmd_q, cmd_d;
  logic [15:0] addr_q, addr_d, req_q, req_d, result_q, result_d;
  logic        status_q, status_d;
  logic [31:0] bp_q, bp_d, asize_q, asize_d, ext_q, ext_d, res_q, res_d;
  logic [31:0] cs_q, cs_d, hx_q, hx_d, hv_q, hv_d;
  logic [31:0] prv_q, prv_d, nxt_q, nxt_d, s2_q, s2_d;
  logic [31:0] size_q, size_d, osize_q, osize_d;

  logic [31:0] brk32, rsz, nb, asz_c;

  assign brk32 = 32'(brk_q);
  assign rsz   = ilha_pkg::tag_size(mem_rdata_i);
  assign nb    = bp_q + rsz;
  assign asz_c = (req_q <= 16'd8) ? ilha_pkg::MIN_BLOCK
               : ((32'(req_q) + 32'd15) & ~32'd7);

  always_comb begin
    state_d     = state_q;
    hret_d      = hret_q;
    caller_d    = caller_q;
    brk_d       = brk_q;
    ok_d        = ok_q;
    pa_d        = pa_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    req_d       = req_q;
    result_d    = result_q;
    status_d    = status_q;
    bp_d        = bp_q;
    asize_d     = asize_q;
    ext_d       = ext_q;
    res_d       = res_q;
    cs_d        = cs_q;
    hx_d        = hx_q;
    hv_d        = hv_q;
    prv_d       = prv_q;
    nxt_d       = nxt_q;
    s2_d        = s2_q;
    size_d      = size_q;
    osize_d     = osize_q;
    mem_req_o   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = ilha_pkg::cmd_e'(cmd_i);
          addr_d = block_addr_i;
          req_d  = request_bytes_i;
          ok_d   = 1'b1;
          res_d  = '0;
          if (ilha_pkg::cmd_e'(cmd_i) == ilha_pkg::CMD_INIT) begin
            brk_d   = BW'(16);
            state_d = S_INIT0;
          end else if (brk_q == '0) begin
            ok_d    = 1'b0;
            state_d = S_DONE;
          end else if (ilha_pkg::cmd_e'(cmd_i) == ilha_pkg::CMD_FREE) begin
            state_d = S_FREE;
          end else begin
            state_d = S_PUT1;
            if (request_bytes_i == 16'd0) begin
              ok_d    = 1'b0;
              state_d = S_DONE;
            end else begin
              bp_d    = ilha_pkg::LIST_START;
              state_d = S_FFR;
            end
          end
        end
      end
      S_INIT0: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: 32'd0, wdata: 32'd0};
        state_d   = S_INIT1;
      end
      S_INIT1: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: 32'd4,
                      wdata: ilha_pkg::DSIZE | ilha_pkg::TAG_ALLOC};
        state_d   = S_INIT2;
      end
      S_INIT2: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: 32'd8,
                      wdata: ilha_pkg::DSIZE | ilha_pkg::TAG_ALLOC};
        state_d   = S_INIT3;
      end
      S_INIT3: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: 32'd12, wdata: ilha_pkg::TAG_ALLOC};
        ext_d     = ilha_pkg::CHUNK_BYTES;
        caller_d  = C_INIT;
        state_d   = S_EXT;
      end
      S_EXT: begin
        if (ext_q > HEAP32 - brk32) begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          bp_d    = brk32;
          brk_d   = brk_q + BW'(ext_q);
          hx_d    = brk32;
          hv_d    = ext_q;
          hret_d  = S_EXTW2;
          state_d = S_HFW;
        end
      end
      S_EXTW2: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: bp_q + ext_q - ilha_pkg::WSIZE,
                      wdata: ilha_pkg::TAG_ALLOC};
        state_d   = S_MG0;
      end
      S_FFR: begin
        asize_d = asz_c;
        if (bp_q - ilha_pkg::WSIZE < brk32) begin
          mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::WSIZE, wdata: '0};
          state_d   = S_FFD;
        end else begin
          ext_d    = (asz_c > ilha_pkg::CHUNK_BYTES) ? asz_c : ilha_pkg::CHUNK_BYTES;
          caller_d = C_ALLOC;
          state_d  = S_EXT;
        end
      end
      S_FFD: begin
        if (rsz != '0 && !mem_rdata_i[0] && rsz >= asize_q) begin
          state_d = S_PUT;
        end else if (rsz == '0 || nb <= bp_q) begin
          ext_d    = (asize_q > ilha_pkg::CHUNK_BYTES) ? asize_q : ilha_pkg::CHUNK_BYTES;
          caller_d = C_ALLOC;
          state_d  = S_EXT;
        end else begin
          bp_d    = nb;
          state_d = S_FFR;
        end
      end
      S_PUT: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::WSIZE, wdata: '0};
        res_d     = bp_q;
        state_d   = S_PUT1;
      end
      S_PUT1: begin
        cs_d    = rsz;
        hx_d    = bp_q;
        state_d = S_HFW;
        if (rsz - asize_q >= ilha_pkg::MIN_BLOCK) begin
          hv_d   = asize_q | ilha_pkg::TAG_ALLOC;
          hret_d = S_PSR2;
        end else begin
          hv_d   = rsz | ilha_pkg::TAG_ALLOC;
          hret_d = S_ADONE;
        end
      end
      S_PSR2: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_PSN;
      end
      S_PSN: begin
        hx_d    = nb;
        hv_d    = cs_q - asize_q;
        hret_d  = S_ADONE;
        state_d = S_HFW;
      end
      S_ADONE: begin
        if (cmd_q == ilha_pkg::CMD_REALLOC) begin
          state_d = S_FREE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FREE: begin
        if (addr_q == 16'd0) begin
          state_d = S_DONE;
        end else begin
          bp_d      = 32'(addr_q);
          mem_req_o = '{we: 1'b0, re: 1'b1, addr: 32'(addr_q) - ilha_pkg::WSIZE,
                        wdata: '0};
          state_d   = S_FR1;
        end
      end
      S_FR1: begin
        hx_d     = bp_q;
        hv_d     = rsz;
        hret_d   = S_MG0;
        caller_d = C_FREE;
        state_d  = S_HFW;
      end
      S_HFW: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: hx_q - ilha_pkg::WSIZE, wdata: hv_q};
        state_d   = S_HFR;
      end
      S_HFR: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: hx_q - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_HFF;
      end
      S_HFF: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: hx_q + rsz - ilha_pkg::DSIZE,
                      wdata: hv_q};
        state_d   = hret_q;
      end
      S_MG0: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::DSIZE, wdata: '0};
        state_d   = S_MG1;
      end
      S_MG1: begin
        prv_d     = bp_q - rsz;
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - rsz - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_MG2;
      end
      S_MG2: begin
        s2_d      = rsz;
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: prv_q + rsz - ilha_pkg::DSIZE, wdata: '0};
        state_d   = S_MG3;
      end
      S_MG3: begin
        pa_d      = mem_rdata_i[0];
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_MG4;
      end
      S_MG4: begin
        size_d    = rsz;
        osize_d   = rsz;
        nxt_d     = nb;
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: nb - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_MG5;
      end
      S_MG5: begin
        if (pa_q && mem_rdata_i[0]) begin
          state_d = S_MRET;
        end else if (pa_q) begin
          hx_d    = bp_q;
          hv_d    = size_q + rsz;
          hret_d  = S_MRET;
          state_d = S_HFW;
        end else if (mem_rdata_i[0]) begin
          size_d  = size_q + s2_q;
          state_d = S_MBW0;
        end else begin
          mem_req_o = '{we: 1'b0, re: 1'b1, addr: nxt_q + rsz - ilha_pkg::DSIZE,
                        wdata: '0};
          state_d   = S_MC0;
        end
      end
      S_MBW0: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: bp_q + osize_q - ilha_pkg::DSIZE,
                      wdata: size_q};
        state_d   = S_MBR0;
      end
      S_MBR0: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::DSIZE, wdata: '0};
        state_d   = S_MBR1;
      end
      S_MBR1: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: bp_q - rsz - ilha_pkg::WSIZE,
                      wdata: size_q};
        bp_d      = bp_q - rsz;
        state_d   = S_MRET;
      end
      S_MC0: begin
        size_d    = size_q + s2_q + rsz;
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::DSIZE, wdata: '0};
        state_d   = S_MCW0;
      end
      S_MCW0: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: bp_q - rsz - ilha_pkg::WSIZE,
                      wdata: size_q};
        state_d   = S_MCR1;
      end
      S_MCR1: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_MCR2;
      end
      S_MCR2: begin
        nxt_d     = nb;
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: nb - ilha_pkg::WSIZE, wdata: '0};
        state_d   = S_MCW1;
      end
      S_MCW1: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: nxt_q + rsz - ilha_pkg::DSIZE,
                      wdata: size_q};
        state_d   = S_MCR3;
      end
      S_MCR3: begin
        mem_req_o = '{we: 1'b0, re: 1'b1, addr: bp_q - ilha_pkg::DSIZE, wdata: '0};
        state_d   = S_MCF;
      end
      S_MCF: begin
        bp_d    = bp_q - rsz;
        state_d = S_MRET;
      end
      S_MRET: begin
        unique case (caller_q)
          C_ALLOC: state_d = S_PUT;
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          result_d    = ok_q ? res_q[15:0] : 16'd0;
          status_d    = !ok_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      brk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hret_q   <= hret_d;
    caller_q <= caller_d;
    ok_q     <= ok_d;
    pa_q     <= pa_d;
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    req_q    <= req_d;
    result_q <= result_d;
    status_q <= status_d;
    bp_q     <= bp_d;
    asize_q  <= asize_d;
    ext_q    <= ext_d;
    res_q    <= res_d;
    cs_q     <= cs_d;
    hx_q     <= hx_d;
    hv_q     <= hv_d;
    prv_q    <= prv_d;
    nxt_q    <= nxt_d;
    s2_q     <= s2_d;
    size_q   <= size_d;
    osize_q  <= osize_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_addr_o = result_q;
  assign status_o      = status_q;

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("read and write in one cycle");

  a_brk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(brk_q) <= HEAP32)
    else $error("break past heap end");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted without leaving idle");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (result_addr_o == 16'd0))
    else $error("failed request carries an address");

endmodule

// ===== design/implicit_list_heap_allocator.sv =====
// Top level of the first-fit boundary-tag heap allocator.
//
// Requests enter on cmd_i/block_addr_i/request_bytes_i with in_valid_i; one is
// taken when in_valid_i is high and in_stall_o is low. Every request gives one
// response on result_addr_o/status_o with out_valid_o, taken when out_stall_i
// is low. Requests are processed one at a time; in_stall_o stays high until
// the response is in the output register.
// Init lays down the prologue and epilogue tags and extends the heap by one
// chunk. Allocate walks the blocks first-fit, splits the chosen block when
// the rest is large enough, and first grows and coalesces the heap when no
// block fits. Free coalesces with free neighbours. Reallocate is an allocate
// followed, if it succeeds, by a free; all use the single heap memory port.
// Reset clears the break, so everything but init fails until init is done;
// heap contents need no clearing. A stalled response holds in the output
// register, and a following request is accepted but waits to respond.
module implicit_list_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] block_addr_i,
  input  logic [15:0] request_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_addr_o,
  output logic        status_o
);

  ilha_pkg::mem_req_t mem_req;
  logic [31:0]        mem_rdata;

  ilha_ctrl #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .block_addr_i   (block_addr_i),
    .request_bytes_i(request_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_addr_o  (result_addr_o),
    .status_o       (status_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  ilha_mem #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_mem (
    .clk_i      (clk_i),
    .mem_req_i  (mem_req),
    .mem_rdata_o(mem_rdata)
  );

endmodule

// ===== verif/implicit_list_heap_allocator_tb.sv =====
// Testbench for the heap allocator: drives directed and random request mixes and checks every response.
module implicit_list_heap_allocator_tb;

  localparam int unsigned HEAP = 65536;
  localparam int unsigned WORDS = HEAP / 4;

  class heap_scoreboard;
    logic [31:0] heap [WORDS];
    logic [31:0] brk;
    logic [15:0] live [$];
    logic [15:0] want_addr [$];
    logic        want_status [$];
    int          errors;

    function new();
      brk = 0;
      errors = 0;
    endfunction

    function logic [31:0] rd(logic [31:0] off);
      return ((off >> 2) < WORDS) ? heap[off >> 2] : 32'd0;
    endfunction

    function void wr(logic [31:0] off, logic [31:0] v);
      if ((off >> 2) < WORDS) heap[off >> 2] = v;
    endfunction

    function logic [31:0] sz(logic [31:0] off);
      return rd(off) & ~32'd7;
    endfunction

    function logic [31:0] nxt(logic [31:0] bp);
      return bp + sz(bp - 4);
    endfunction

    function logic [31:0] prv(logic [31:0] bp);
      return bp - sz(bp - 8);
    endfunction

    function logic [31:0] ftr(logic [31:0] bp);
      return bp + sz(bp - 4) - 8;
    endfunction

    function bit grow(logic [31:0] n, output logic [31:0] old);
      old = 0;
      if (n > HEAP - brk) return 1'b0;
      old = brk;
      brk = brk + n;
      return 1'b1;
    endfunction

    function logic [31:0] coalesce(logic [31:0] bp);
      logic pa, na;
      logic [31:0] size;
      pa = |(rd(ftr(prv(bp))) & 32'd1);
      na = |(rd(nxt(bp) - 4) & 32'd1);
      size = sz(bp - 4);
      if (pa && na) return bp;
      if (pa) begin
        size = size + sz(nxt(bp) - 4);
        wr(bp - 4, size);
        wr(ftr(bp), size);
      end else if (na) begin
        size = size + sz(prv(bp) - 4);
        wr(ftr(bp), size);
        wr(prv(bp) - 4, size);
        bp = prv(bp);
      end else begin
        size = size + sz(prv(bp) - 4) + sz(ftr(nxt(bp)));
        wr(prv(bp) - 4, size);
        wr(ftr(nxt(bp)), size);
        bp = prv(bp);
      end
      return bp;
    endfunction

    function bit extend(logic [31:0] n, output logic [31:0] bp);
      logic [31:0] b;
      bp = 0;
      if (!grow(n, b)) return 1'b0;
      wr(b - 4, n);
      wr(ftr(b), n);
      wr(nxt(b) - 4, ilha_pkg::TAG_ALLOC);
      bp = coalesce(b);
      return 1'b1;
    endfunction

    function logic [31:0] first_fit(logic [31:0] asize);
      logic [31:0] bp, nb;
      bp = ilha_pkg::LIST_START;
      while (bp - 4 < brk && sz(bp - 4) != 0) begin
        if (!(rd(bp - 4) & 1) && sz(bp - 4) >= asize) return bp;
        nb = nxt(bp);
        if (nb <= bp) return 32'd0;
        bp = nb;
      end
      return 32'd0;
    endfunction

    function bit allocate(logic [31:0] req, output logic [31:0] bp);
      logic [31:0] asize, csize;
      bp = 0;
      if (req == 0) return 1'b0;
      asize = (req <= ilha_pkg::DSIZE) ? ilha_pkg::MIN_BLOCK : 8 * ((req + 15) / 8);
      bp = first_fit(asize);
      if (bp == 0)
        if (!extend(asize > ilha_pkg::CHUNK_BYTES ? asize : ilha_pkg::CHUNK_BYTES, bp))
          return 1'b0;
      csize = sz(bp - 4);
      if (csize - asize >= ilha_pkg::MIN_BLOCK) begin
        wr(bp - 4, asize | 1);
        wr(ftr(bp), asize | 1);
        wr(nxt(bp) - 4, csize - asize);
        wr(ftr(nxt(bp)), csize - asize);
      end else begin
        wr(bp - 4, csize | 1);
        wr(ftr(bp), csize | 1);
      end
      live.push_back(bp[15:0]);
      return 1'b1;
    endfunction

    function void release_block(logic [31:0] bp);
      logic [31:0] size;
      if (bp == 0) return;
      size = sz(bp - 4);
      wr(bp - 4, size);
      wr(ftr(bp), size);
      void'(coalesce(bp));
      foreach (live[i])
        if (live[i] == bp[15:0]) begin
          live.delete(i);
          break;
        end
    endfunction

    function void note(ilha_pkg::cmd_e c, logic [15:0] a, logic [15:0] r);
      logic [31:0] bp, base;
      bit ok;
      bp = 0;
      ok = 1;
      if (c == ilha_pkg::CMD_INIT) begin
        brk = 0;
        live.delete();
        void'(grow(16, base));
        wr(base, 0);
        wr(base + 4, ilha_pkg::DSIZE | 1);
        wr(base + 8, ilha_pkg::DSIZE | 1);
        wr(base + 12, ilha_pkg::TAG_ALLOC);
        ok = extend(ilha_pkg::CHUNK_BYTES, bp);
        bp = 0;
      end else if (brk == 0) begin
        ok = 0;
      end else if (c == ilha_pkg::CMD_ALLOC) begin
        ok = allocate(r, bp);
      end else if (c == ilha_pkg::CMD_FREE) begin
        release_block(a);
      end else begin
        ok = allocate(r, bp);
        if (ok) release_block(a);
      end
      want_addr.push_back(ok ? bp[15:0] : 16'd0);
      want_status.push_back(!ok);
    endfunction

    function void check(logic [15:0] a, logic s);
      if (want_addr.size() == 0) begin
        $display("%0t: unexpected response addr %h status %b", $time, a, s);
        errors++;
        return;
      end
      if (a !== want_addr[0]) begin
        $display("%0t: result_addr expected %h actual %h", $time, want_addr[0], a);
        errors++;
      end
      if (s !== want_status[0]) begin
        $display("%0t: status expected %b actual %b", $time, want_status[0], s);
        errors++;
      end
      void'(want_addr.pop_front());
      void'(want_status.pop_front());
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  cmd_i;
  logic [15:0] block_addr_i, request_bytes_i;
  logic        out_valid_o, out_stall_i;
  logic [15:0] result_addr_o;
  logic        status_o;

  heap_scoreboard sb;
  int unsigned send_idle, recv_idle, hold_off;

  implicit_list_heap_allocator dut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i = 1'b1;
      hold_off = hold_off - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(result_addr_o, status_o);

  task automatic send(ilha_pkg::cmd_e c, logic [15:0] a, logic [15:0] r);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = c;
    block_addr_i = a;
    request_bytes_i = r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(c, a, r);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_live();
    if (sb.live.size() == 0) return 16'd0;
    return sb.live[$urandom_range(sb.live.size() - 1)];
  endfunction

  function automatic logic [15:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return 16'd0;
    if (p < 6) return 16'($urandom_range(65535));
    if (p < 16) return 16'($urandom_range(2000, 1));
    return 16'($urandom_range(200, 1));
  endfunction

  task automatic rand_item();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 2) send(ilha_pkg::CMD_INIT, 16'($urandom), 16'($urandom));
    else if (p < 50) send(ilha_pkg::CMD_ALLOC, 16'($urandom), rand_size());
    else if (p < 78) send(ilha_pkg::CMD_FREE, pick_live(), 16'($urandom));
    else if (p < 80) send(ilha_pkg::CMD_FREE, 16'd0, 16'($urandom));
    else send(ilha_pkg::CMD_REALLOC, ($urandom_range(9) == 0) ? 16'd0 : pick_live(),
              rand_size());
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.want_addr.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_idle = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = ilha_pkg::CMD_INIT;
    block_addr_i = '0;
    request_bytes_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // before init: everything fails
    send(ilha_pkg::CMD_ALLOC, 16'hFFFF, 16'hFFFF);
    send(ilha_pkg::CMD_FREE, 16'hFFFF, 16'h0000);
    send(ilha_pkg::CMD_REALLOC, 16'h0000, 16'hFFFF);
    send(ilha_pkg::CMD_INIT, 16'h5555, 16'hAAAA);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd0);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd1);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd8);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd9);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd24);
    send(ilha_pkg::CMD_FREE, pick_live(), 16'd0);
    send(ilha_pkg::CMD_FREE, 16'd0, 16'd0);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd4096);
    send(ilha_pkg::CMD_REALLOC, 16'd0, 16'd40);
    send(ilha_pkg::CMD_REALLOC, pick_live(), 16'd100);
    send(ilha_pkg::CMD_REALLOC, pick_live(), 16'd0);
    send(ilha_pkg::CMD_FREE, pick_live(), 16'd0);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'hFFFF);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd30000);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd30000);
    send(ilha_pkg::CMD_REALLOC, pick_live(), 16'd40000);
    send(ilha_pkg::CMD_FREE, pick_live(), 16'd0);
    send(ilha_pkg::CMD_ALLOC, 16'h0, 16'd3);
    send(ilha_pkg::CMD_INIT, 16'h0, 16'h0);

    send_idle = 25;
    recv_idle = 50;
    repeat (200) rand_item();
    hold_off = 400;
    repeat (20) rand_item();
    drain();
    send_idle = 50;
    recv_idle = 25;
    repeat (200) rand_item();
    send_idle = 0;
    recv_idle = 0;
    repeat (200) rand_item();

    drain();
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.want_addr.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
